@@ design/sbo_pkg.sv @@
// shared types and constants of the select-before-operate table
package sbo_pkg;

	localparam logic [31:0] DEFAULT_TIMEOUT_RESET = 32'd30000;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_SELECT   = 2'd1,
		OP_OPERATE  = 2'd2,
		OP_CANCEL   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_SELECTED = 3'd1,
		ST_TIMED_OUT    = 3'd2,
		ST_FULL         = 3'd3,
		ST_UNREGISTERED = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// one table entry as held in the ram
	typedef struct packed {
		logic [31:0] tmo_ms;
		logic [31:0] sel_ms;
	} entry_t;

	// one input beat after capture
	typedef struct packed {
		op_t         op;
		logic [5:0]  idx;
		logic [31:0] tmo_ms;
		logic        is_bool;
		logic        cmd;
		logic        test;
		logic [31:0] now_ms;
	} item_t;

	// table facts the evaluator needs about the addressed point
	typedef struct packed {
		logic       full;
		logic       registered;
		logic       flag;
		logic [5:0] slot;
	} ctx_t;

	// writeback requests from the evaluator
	typedef struct packed {
		logic   mem_we;
		entry_t entry;
		logic   flag_we;
		logic   flag_val;
		logic   count_inc;
	} upd_t;

	// one result beat
	typedef struct packed {
		logic       cmd;
		logic       fired;
		logic [5:0] assigned;
		status_t    status;
	} res_t;

endpackage

@@ design/sbo_entry_ram.sv @@
// table ram holding select time and timeout of each point, registered read
module sbo_entry_ram import sbo_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/sbo_eval.sv @@
// decides the result of one command and the table updates it causes
module sbo_eval import sbo_pkg::*; (
	input  item_t       item,
	input  ctx_t        ctx,
	input  entry_t      rd,
	input  logic [31:0] dflt_ms,
	output res_t        res,
	output upd_t        upd
);

	logic [31:0] elapsed;

	// elapsed time wraps modulo 2^32
	assign elapsed = item.now_ms - rd.sel_ms;

	// command decode
	always_comb begin
		res.status   = ST_OK;
		res.assigned = item.idx;
		res.fired    = 1'b0;
		res.cmd      = 1'b0;
		upd.mem_we    = 1'b0;
		upd.entry     = rd;
		upd.flag_we   = 1'b0;
		upd.flag_val  = 1'b0;
		upd.count_inc = 1'b0;
		case (item.op)
			OP_REGISTER: begin
				if (ctx.full) begin
					res.status = ST_FULL;
				end else begin
					upd.mem_we       = 1'b1;
					upd.entry.tmo_ms = (item.tmo_ms != 32'd0) ? item.tmo_ms : dflt_ms;
					upd.entry.sel_ms = 32'd0;
					upd.flag_we      = 1'b1;
					upd.count_inc    = 1'b1;
					res.assigned     = ctx.slot;
				end
			end
			default: begin
				if (!ctx.registered) begin
					res.status = ST_UNREGISTERED;
				end else if (!item.test) begin
					case (item.op)
						OP_SELECT: begin
							upd.mem_we       = 1'b1;
							upd.entry.sel_ms = item.now_ms;
							upd.flag_we      = 1'b1;
							upd.flag_val     = 1'b1;
						end
						OP_OPERATE: begin
							if (!ctx.flag) begin
								res.status = ST_NOT_SELECTED;
							end else if (elapsed > rd.tmo_ms) begin
								res.status  = ST_TIMED_OUT;
								upd.flag_we = 1'b1;
							end else begin
								upd.mem_we       = 1'b1;
								upd.entry.sel_ms = 32'd0;
								upd.flag_we      = 1'b1;
								res.fired        = 1'b1;
								res.cmd          = item.is_bool & item.cmd;
							end
						end
						default: begin
							upd.mem_we       = 1'b1;
							upd.entry.sel_ms = 32'd0;
							upd.flag_we      = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

endmodule

@@ design/select_before_operate_table_unit.sv @@
// Select-before-operate control table: register, select, operate and cancel commands on up
// to POINTS control points. Each command beat has the point's entry read from the ram as it
// is accepted, then is evaluated and written back once the output register is free; the unit
// then takes the next beat. The result waits in an output register; a second command is
// accepted meanwhile but its evaluation holds until the pending result is taken. Selected
// flags live in flip-flops cleared by reset, so no clearing pass follows reset.
// default_timeout_ms may only be written while no command is in flight.
module select_before_operate_table_unit import sbo_pkg::*; #(
	parameter int POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: default_timeout_ms
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// command beats
	input  logic        s_tvalid,
	output logic        s_tready,
	// point_index[5:0], timeout_ms[37:6], command_value[38], now_ms[70:39], zero fill
	input  logic [71:0] s_tdata,
	// operation[1:0], value_is_boolean[2], test_mode[3]
	input  logic [3:0]  s_tuser,
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], assigned_index[8:3], operate_fired[9], command_out[10], zero fill
	output logic [15:0] m_tdata
);

	localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW = $clog2(POINTS + 1);
	localparam int IW = (AW > 6) ? AW : 6;
	localparam int KW = (CW > 6) ? CW : 6;

	fsm_t        state_q, state_d;
	item_t       item_s1, item_in;
	logic [CW-1:0] count_q;
	logic [POINTS-1:0] sel_q;
	logic [31:0] dflt_q;
	logic        m_valid_q;
	res_t        res_q, res;
	upd_t        upd;
	ctx_t        ctx;
	entry_t      rd;
	logic        accept, exec_go;
	logic [IW-1:0] idx_in_w, idx_s1_w;
	logic [AW-1:0] raddr, waddr, idx_a;

	// unpack the input beat
	assign item_in.op      = op_t'(s_tuser[1:0]);
	assign item_in.is_bool = s_tuser[2];
	assign item_in.test    = s_tuser[3];
	assign item_in.idx     = s_tdata[5:0];
	assign item_in.tmo_ms  = s_tdata[37:6];
	assign item_in.cmd     = s_tdata[38];
	assign item_in.now_ms  = s_tdata[70:39];

	// control fsm
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!m_valid_q || m_tready) begin
					exec_go = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// ram addresses from the point index, or from the fill count for a register
	assign idx_in_w = IW'(item_in.idx);
	assign idx_s1_w = IW'(item_s1.idx);
	assign raddr    = idx_in_w[AW-1:0];
	assign idx_a    = idx_s1_w[AW-1:0];
	assign waddr    = (item_s1.op == OP_REGISTER) ? count_q[AW-1:0] : idx_a;

	sbo_entry_ram #(
		.DEPTH (POINTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (exec_go & upd.mem_we),
		.waddr (waddr),
		.wdata (upd.entry),
		.re    (accept),
		.raddr (raddr),
		.rdata (rd)
	);

	// table facts for the addressed point
	assign ctx.full       = (count_q == CW'(POINTS));
	assign ctx.registered = (KW'(item_s1.idx) < KW'(count_q));
	assign ctx.flag       = sel_q[idx_a];
	assign ctx.slot       = 6'(count_q);

	sbo_eval u_eval (
		.item    (item_s1),
		.ctx     (ctx),
		.rd      (rd),
		.dflt_ms (dflt_q),
		.res     (res),
		.upd     (upd)
	);

	// count, selected flags and default timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sel_q   <= '0;
			dflt_q  <= DEFAULT_TIMEOUT_RESET;
		end else begin
			if (cfg_wr_en) begin
				dflt_q <= cfg_wr_data;
			end
			if (exec_go && upd.count_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (exec_go && upd.flag_we) begin
				sel_q[waddr] <= upd.flag_val;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (exec_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q.cmd, res_q.fired, res_q.assigned, res_q.status};

`ifndef NO_ASSERTIONS
	// the fill count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(count_q) <= KW'(POINTS))
		else $error("fill count beyond table size");

	// a finished command always leaves a result beat
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> m_valid_q)
		else $error("finished command left no result");

	// a successful register grows the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && upd.count_inc |=> count_q == $past(count_q) + CW'(1))
		else $error("register did not advance the fill count");

	// a fired operate reports ok
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.fired |-> res_q.status == ST_OK)
		else $error("operate fired with a failure status");

	// no result is overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |-> !m_valid_q || m_tready)
		else $error("pending result overwritten");
`endif

endmodule
